### src/tccc_pkg.sv
package tccc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 6;
  localparam int CNT_W      = 8;
  localparam int ROWS_CFG_W = 7;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_LIMIT = 2'd2;

  localparam logic [COL_W-1:0]      COLUMNS_RST    = 8'd80;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RST       = 7'd25;
  localparam logic [CNT_W-1:0]      SWAP_LIMIT_RST = 8'd8;

  typedef struct packed {
    logic [COL_W-1:0]      columns;
    logic [ROWS_CFG_W-1:0] rows;
    logic [CNT_W-1:0]      swap_limit;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [CNT_W-1:0]    cnt;
    logic [MAX_ROWS-1:0] dirty;
  } state_t;

  typedef struct packed {
    logic                draw_valid;
    logic [COL_W-1:0]    draw_col;
    logic [ROW_W-1:0]    draw_row;
    logic [CHAR_W-1:0]   draw_char;
    logic                scrolled;
    logic                swap_request;
    logic [MAX_ROWS-1:0] flushed_rows;
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
  } result_t;

endpackage

### src/text_console_cursor_control_core.sv
// text console cursor control
// input channel: in_valid / in_ready carry one character request
// (in_char_code, in_count_newline). the block moves the cursor, counts
// newlines toward a buffer swap and tracks dirty rows.
// result channel: out_valid / out_ready carry one result per request: the
// cell draw command, scroll and swap flags, flushed row bitmap and cursor.
// configuration: cfg_wr_en with cfg_index (0 columns, 1 rows, 2 swap limit)
// and cfg_wdata; write only while the block is idle.
// path: a request is held in the input register, then the cursor logic
// writes its result into the result register.
// throughput: one request per cycle, limited only by the result register.
// when the receiver stalls, the result holds and one more request can sit
// in the input register; in_ready drops once both are full.
// reset: cursor at column 0 row 0, counter and dirty map cleared, registers
// back to 80 columns, 25 rows and a swap limit of 8.
module text_console_cursor_control_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tccc_pkg::CHAR_W-1:0]           in_char_code,
  input  logic                                  in_count_newline,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_draw_valid,
  output logic [tccc_pkg::COL_W-1:0]            out_draw_col,
  output logic [tccc_pkg::ROW_W-1:0]            out_draw_row,
  output logic [tccc_pkg::CHAR_W-1:0]           out_draw_char,
  output logic                                  out_scrolled,
  output logic                                  out_swap_request,
  output logic [tccc_pkg::MAX_ROWS-1:0]         out_flushed_rows,
  output logic [tccc_pkg::COL_W-1:0]            out_cursor_col,
  output logic [tccc_pkg::ROW_W-1:0]            out_cursor_row
);
  import tccc_pkg::*;

  cfg_t              cfg_r;
  state_t            st_r;
  state_t            st_nxt;
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_count_r;
  logic              ld_ready;
  logic              advance;
  result_t           step_res;
  result_t           out_res;

  assign advance  = s1_valid_r && ld_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns    <= COLUMNS_RST;
      cfg_r.rows       <= ROWS_RST;
      cfg_r.swap_limit <= SWAP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLUMNS:    cfg_r.columns    <= cfg_wdata;
        CFG_ROWS:       cfg_r.rows       <= cfg_wdata[ROWS_CFG_W-1:0];
        CFG_SWAP_LIMIT: cfg_r.swap_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_code;
      s1_count_r <= in_count_newline;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  tccc_step u_step (
    .cfg           (cfg_r),
    .st            (st_r),
    .char_code     (s1_char_r),
    .count_newline (s1_count_r),
    .st_nxt        (st_nxt),
    .res           (step_res)
  );

  tccc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load_ready (ld_ready),
    .load_res   (step_res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_draw_valid   = out_res.draw_valid;
  assign out_draw_col     = out_res.draw_col;
  assign out_draw_row     = out_res.draw_row;
  assign out_draw_char    = out_res.draw_char;
  assign out_scrolled     = out_res.scrolled;
  assign out_swap_request = out_res.swap_request;
  assign out_flushed_rows = out_res.flushed_rows;
  assign out_cursor_col   = out_res.cursor_col;
  assign out_cursor_row   = out_res.cursor_row;

  a_scroll_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_swap_request && !out_draw_valid ||
      out_valid && out_scrolled && out_draw_valid && out_cursor_col == COL_W'(1))
    else $error("scroll without swap or with bad cursor column");

  a_flush_only_on_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_swap_request |-> out_flushed_rows == '0)
    else $error("rows flushed without a swap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(out_valid && !out_ready))
    else $error("result register overwritten while stalled");

  a_cursor_row_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> st_r.dirty[st_r.row])
    else $error("cursor row not marked dirty");

endmodule

### src/tccc_step.sv
module tccc_step (
  input  tccc_pkg::cfg_t                cfg,
  input  tccc_pkg::state_t              st,
  input  logic [tccc_pkg::CHAR_W-1:0]   char_code,
  input  logic                          count_newline,
  output tccc_pkg::state_t              st_nxt,
  output tccc_pkg::result_t             res
);
  import tccc_pkg::*;

  logic [ROWS_CFG_W-1:0] eff_rows;
  logic [MAX_ROWS-1:0]   mask;
  logic                  nl_scroll;
  logic [ROW_W-1:0]      nl_row;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_inc;
  logic [MAX_ROWS-1:0]   dirty;
  logic [MAX_ROWS-1:0]   flushed;
  logic                  swap;
  logic                  scroll;
  logic                  draw;
  logic [COL_W-1:0]      dcol;
  logic [ROW_W-1:0]      drow;
  logic [CHAR_W-1:0]     dchar;
  logic [COL_W:0]        tab_sum;

  always_comb begin
    if (cfg.rows == '0) begin
      eff_rows = ROWS_CFG_W'(1);
    end else if (cfg.rows > ROWS_CFG_W'(MAX_ROWS)) begin
      eff_rows = ROWS_CFG_W'(MAX_ROWS);
    end else begin
      eff_rows = cfg.rows;
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      mask[i] = (ROWS_CFG_W'(i) < eff_rows);
    end
  end

  assign nl_scroll = ({1'b0, st.row} + ROWS_CFG_W'(1)) >= eff_rows;
  assign nl_row    = nl_scroll ? ROW_W'(eff_rows - ROWS_CFG_W'(1)) : st.row + ROW_W'(1);

  always_comb begin
    col     = st.col;
    row     = st.row;
    cnt     = st.cnt;
    dirty   = st.dirty;
    flushed = '0;
    swap    = 1'b0;
    scroll  = 1'b0;
    draw    = 1'b0;
    dcol    = '0;
    drow    = '0;
    dchar   = '0;
    cnt_inc = '0;
    tab_sum = '0;
    case (char_code)
      CH_NEWLINE: begin
        col = '0;
        row = nl_row;
        if (nl_scroll) begin
          scroll  = 1'b1;
          swap    = 1'b1;
          flushed = mask;
          dirty   = '0;
          cnt     = '0;
        end
        if (count_newline) begin
          cnt_inc = (cnt == '1) ? cnt : cnt + CNT_W'(1);
          if (cnt_inc >= cfg.swap_limit) begin
            swap    = 1'b1;
            flushed = flushed | (dirty & mask);
            dirty   = '0;
            cnt     = '0;
          end else begin
            cnt = cnt_inc;
          end
        end
      end
      CH_RETURN: begin
        col = '0;
      end
      CH_TAB: begin
        tab_sum = {1'b0, st.col | COL_W'(3)} + (COL_W+1)'(1);
        col     = tab_sum[COL_W] ? '1 : tab_sum[COL_W-1:0];
      end
      CH_BACKSPACE: begin
        col   = (st.col == '0) ? '0 : st.col - COL_W'(1);
        draw  = 1'b1;
        dcol  = col;
        drow  = st.row;
        dchar = CH_BLANK;
      end
      default: begin
        // wrap past the last column
        if (st.col >= cfg.columns) begin
          col = '0;
          row = nl_row;
          if (nl_scroll) begin
            scroll  = 1'b1;
            swap    = 1'b1;
            flushed = mask;
            dirty   = '0;
            cnt     = '0;
          end
        end
        draw  = 1'b1;
        dcol  = col;
        drow  = row;
        dchar = char_code;
        col   = (col == '1) ? col : col + COL_W'(1);
      end
    endcase
    dirty = dirty | ({{(MAX_ROWS-1){1'b0}}, 1'b1} << row);

    st_nxt.col   = col;
    st_nxt.row   = row;
    st_nxt.cnt   = cnt;
    st_nxt.dirty = dirty;

    res.draw_valid   = draw;
    res.draw_col     = dcol;
    res.draw_row     = drow;
    res.draw_char    = dchar;
    res.scrolled     = scroll;
    res.swap_request = swap;
    res.flushed_rows = flushed;
    res.cursor_col   = col;
    res.cursor_row   = row;
  end

endmodule

### src/tccc_out_reg.sv
module tccc_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  output logic               load_ready,
  input  tccc_pkg::result_t  load_res,
  output logic               out_valid,
  input  logic               out_ready,
  output tccc_pkg::result_t  out_res
);
  import tccc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign load_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
